/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes shared by the first-fit block allocator and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    // Field types of the request and result channels
    typedef logic [15:0] bytes_t;
    typedef logic [11:0] offset_t;
    typedef logic [1:0]  status_t;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_SIZE  = 2'd1;
    localparam status_t STATUS_NO_SPACE  = 2'd2;
    localparam status_t STATUS_NO_BLOCK  = 2'd3;

    // One granule of the block map: start mark and free bit
    typedef struct packed {
        logic start;
        logic free;
    } map_entry_t;

    localparam map_entry_t ENTRY_NONE = '{start: 1'b0, free: 1'b0};
    localparam map_entry_t ENTRY_USED = '{start: 1'b1, free: 1'b0};
    localparam map_entry_t ENTRY_FREE = '{start: 1'b1, free: 1'b1};

endpackage

`default_nettype wire

/* rtl/ffba_req_if.sv */
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel of the allocator: valid/ready with mode, size and offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffba_req_if;
    import ffba_pkg::*;

    logic    valid;
    logic    ready;
    logic    mode;
    bytes_t  request_bytes;
    offset_t block_offset;

    modport source (output valid, output mode, output request_bytes,
                    output block_offset, input ready);
    modport sink   (input valid, input mode, input request_bytes,
                    input block_offset, output ready);
endinterface

`default_nettype wire

/* rtl/ffba_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Result channel of the allocator: valid/ready with granted offset and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffba_rsp_if;
    import ffba_pkg::*;

    logic    valid;
    logic    ready;
    offset_t granted_offset;
    status_t status;

    modport source (output valid, output granted_offset, output status,
                    input ready);
    modport sink   (input valid, input granted_offset, input status,
                    output ready);
endinterface

`default_nettype wire

/* rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with coalescing over one page, kept as a granule map
// (start mark and free bit per granule) in a synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel  Modport  Payload                               Role
//  -------  -------  ------------------------------------  -------------------
//  req      sink     mode, request_bytes, block_offset     allocate / free
//  rsp      source   granted_offset, status                one result per req
//
//  After reset a clearing pass writes every granule of the map; no request is taken meanwhile.
//  A request is size-checked in S_DIV and S_CHK and the first map read is issued, then
//  walks one granule a cycle: an allocate stops at the first fit, a free at the next block.
//  Up to two map writes (S_WR0, S_WR1) and the result state S_RESP follow.
//  A held result keeps the next request waiting only once its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
    parameter int PAGE_BYTES    = 4096,
    parameter int GRANULE_BYTES = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ffba_req_if.sink    req,
    ffba_rsp_if.source  rsp
);
    import ffba_pkg::*;

    // Map geometry
    localparam int GRAN_COUNT = PAGE_BYTES / GRANULE_BYTES;
    localparam int IDX_W      = (GRAN_COUNT > 1) ? $clog2(GRAN_COUNT) : 1;
    localparam int CNT_W      = $clog2(GRAN_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRAN_COUNT - 1);

    // Division by the granule as a reciprocal multiply
    localparam int DIV_SH     = 16 + $clog2(GRANULE_BYTES);
    localparam int DIV_M      = (2 ** DIV_SH + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int PROD_W     = DIV_SH + 17;
    localparam int CHK_W      = 23;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WR0   = 3'd5;
    localparam logic [2:0] S_WR1   = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]       state_reg;
    logic             mode_reg;
    logic [15:0]      val_reg;
    logic [15:0]      q_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_tag_reg;
    map_entry_t       rd_q_reg;
    logic [IDX_W-1:0] cur_start_reg;
    logic             cur_free_reg;
    logic [CNT_W-1:0] cur_len_reg;
    logic             found_reg;
    logic [IDX_W-1:0] wr0_addr_reg;
    map_entry_t       wr0_data_reg;
    logic             wr1_en_reg;
    logic [IDX_W-1:0] wr1_addr_reg;
    map_entry_t       wr1_data_reg;
    offset_t          res_off_reg;
    status_t          res_status_reg;
    logic             rsp_valid_reg;
    offset_t          rsp_off_reg;
    status_t          rsp_status_reg;

    map_entry_t       map_mem [GRAN_COUNT];

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    map_entry_t       mem_wdata;
    logic             rd_issue;

    logic [PROD_W-1:0] div_prod;
    logic              exact;
    logic [IDX_W-1:0]  new_start;
    logic              new_free;
    logic [CNT_W-1:0]  new_len;
    logic              fit_now;
    logic              is_last;
    logic              slot_free;
    logic [31:0]       grant_prod;
    logic [IDX_W-1:0]  grant_src;

    // Quotient by the granule, and exactness of that quotient
    assign div_prod = PROD_W'(val_reg) * PROD_W'(DIV_M);
    assign exact    = (CHK_W'(q_reg) * CHK_W'(GRANULE_BYTES)) == CHK_W'(val_reg);

    // Running block seen by the allocate walk
    assign new_start = rd_q_reg.start ? rd_tag_reg : cur_start_reg;
    assign new_free  = rd_q_reg.start ? rd_q_reg.free : cur_free_reg;
    assign new_len   = rd_q_reg.start ? CNT_W'(1) : CNT_W'(cur_len_reg + 1'b1);
    assign fit_now   = new_free && (32'(new_len) == 32'(q_reg));
    assign is_last   = (rd_tag_reg == LAST_IDX);

    // Byte offset of the granted block, low bits only
    assign grant_src  = found_reg ? cur_start_reg : new_start;
    assign grant_prod = 32'(grant_src) * 32'(GRANULE_BYTES);

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign rd_issue  = (state_reg == S_SCAN) && (rd_idx_reg < CNT_W'(GRAN_COUNT));

    // Select the single write of this cycle
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr0_addr_reg;
        mem_wdata = wr0_data_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_idx_reg[IDX_W-1:0];
                mem_wdata = (rd_idx_reg == '0) ? ENTRY_FREE : ENTRY_NONE;
            end
            S_WR0:
            begin
                mem_we = 1'b1;
            end
            S_WR1:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr1_addr_reg;
                mem_wdata = wr1_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Granule map memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q_reg <= map_mem[rd_idx_reg[IDX_W-1:0]];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            wr1_en_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_issue;
            if (rd_issue)
            begin
                rd_tag_reg <= rd_idx_reg[IDX_W-1:0];
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    // sweep the map once after reset
                    if (rd_idx_reg[IDX_W-1:0] == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg  <= req.mode;
                        val_reg   <= (req.mode == MODE_FREE) ? 16'(req.block_offset)
                                                             : req.request_bytes;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    q_reg     <= div_prod[DIV_SH +: 16];
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    // reject bad sizes and offsets, else start the walk at zero
                    rd_idx_reg    <= '0;
                    found_reg     <= 1'b0;
                    wr1_en_reg    <= 1'b0;
                    cur_start_reg <= '0;
                    cur_free_reg  <= 1'b0;
                    cur_len_reg   <= '0;
                    res_off_reg   <= '0;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (val_reg == '0 || !exact)
                        begin
                            res_status_reg <= STATUS_BAD_SIZE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        if (!exact || 32'(q_reg) >= 32'(GRAN_COUNT))
                        begin
                            res_status_reg <= STATUS_NO_BLOCK;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_vld_reg)
                    begin
                        if (mode_reg == MODE_ALLOC)
                        begin
                            if (!found_reg)
                            begin
                                // follow the current block and test its size
                                cur_start_reg <= new_start;
                                cur_free_reg  <= new_free;
                                cur_len_reg   <= new_len;
                                if (fit_now)
                                begin
                                    if (is_last)
                                    begin
                                        wr0_addr_reg   <= new_start;
                                        wr0_data_reg   <= ENTRY_USED;
                                        res_off_reg    <= grant_prod[11:0];
                                        res_status_reg <= STATUS_OK;
                                        state_reg      <= S_WR0;
                                    end
                                    else
                                    begin
                                        found_reg <= 1'b1;
                                    end
                                end
                                else if (is_last)
                                begin
                                    res_status_reg <= STATUS_NO_SPACE;
                                    state_reg      <= S_RESP;
                                end
                            end
                            else
                            begin
                                // granule past the fit: split unless a block starts here
                                wr0_addr_reg   <= cur_start_reg;
                                wr0_data_reg   <= ENTRY_USED;
                                wr1_en_reg     <= !rd_q_reg.start;
                                wr1_addr_reg   <= rd_tag_reg;
                                wr1_data_reg   <= ENTRY_FREE;
                                res_off_reg    <= grant_prod[11:0];
                                res_status_reg <= STATUS_OK;
                                state_reg      <= S_WR0;
                            end
                        end
                        else
                        begin
                            if (!found_reg)
                            begin
                                if (rd_tag_reg == q_reg[IDX_W-1:0])
                                begin
                                    // freed granule: must start a block
                                    if (!rd_q_reg.start)
                                    begin
                                        res_status_reg <= STATUS_NO_BLOCK;
                                        state_reg      <= S_RESP;
                                    end
                                    else
                                    begin
                                        found_reg      <= 1'b1;
                                        wr0_addr_reg   <= rd_tag_reg;
                                        wr0_data_reg   <= ((rd_tag_reg != '0) && cur_free_reg)
                                                          ? ENTRY_NONE : ENTRY_FREE;
                                        res_status_reg <= STATUS_OK;
                                        if (is_last)
                                        begin
                                            state_reg <= S_WR0;
                                        end
                                    end
                                end
                                else if (rd_q_reg.start)
                                begin
                                    cur_free_reg <= rd_q_reg.free;
                                end
                            end
                            else
                            begin
                                // next block: absorb it when free
                                if (rd_q_reg.start)
                                begin
                                    wr1_en_reg   <= rd_q_reg.free;
                                    wr1_addr_reg <= rd_tag_reg;
                                    wr1_data_reg <= ENTRY_NONE;
                                    state_reg    <= S_WR0;
                                end
                                else if (is_last)
                                begin
                                    state_reg <= S_WR0;
                                end
                            end
                        end
                    end
                end
                S_WR0:
                begin
                    state_reg <= wr1_en_reg ? S_WR1 : S_RESP;
                end
                S_WR1:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (state_reg == S_RESP && slot_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESP && slot_free)
        begin
            rsp_off_reg    <= res_off_reg;
            rsp_status_reg <= res_status_reg;
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.granted_offset = rsp_off_reg;
    assign rsp.status         = rsp_status_reg;

    // A failed request never carries an offset
    a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STATUS_OK |-> rsp.granted_offset == '0)
        else $error("failed request with non-zero offset");

    // The map is not written while it is being walked
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !mem_we)
        else $error("map write during walk");

    // The second write only follows the first
    a_wr1_after_wr0: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR1 |-> $past(state_reg) == S_WR0 && $past(wr1_en_reg))
        else $error("second write without first");

    // Read data is only in flight from a walk
    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg) == S_SCAN)
        else $error("read outside walk");

    // A new result is loaded only into a free output slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp_status_reg))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the first-fit block allocator. It drives allocate and free
// requests through the request channel and predicts each result from its own
// copy of the granule map. It checks every result field by field, in order.
// Both channels idle at random. After a directed opening the random part
// mostly issues well-formed allocate and free requests with some noise mixed in.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int PAGE_BYTES      = 4096;
    localparam int GRANULE_BYTES   = 8;
    localparam int MAP_GRANULES    = PAGE_BYTES / GRANULE_BYTES;
    localparam int RANDOM_REQUESTS = 1280;
    localparam int SETTLE_CYCLES   = MAP_GRANULES + 64;
    localparam int CLK_HALF        = 2;

    typedef struct packed {
        offset_t granted_offset;
        status_t status;
    } grant_t;

    // Shadow of the granule map with the queue of grants still to come
    class block_map_board;
        bit     start_mark[MAP_GRANULES];
        bit     free_mark[MAP_GRANULES];
        grant_t expected_grants[$];
        int     errors;

        function new();
            errors = 0;
            foreach (start_mark[i])
            begin
                start_mark[i] = 1'b0;
                free_mark[i]  = 1'b0;
            end
            start_mark[0] = 1'b1;
            free_mark[0]  = 1'b1;
        endfunction

        // Granules from start s up to the next start mark or the page end
        function int run_length(int s);
            int j;
            j = s + 1;
            while (j < MAP_GRANULES && !start_mark[j])
                j++;
            return j - s;
        endfunction

        function grant_t allocate(bytes_t size);
            grant_t g;
            int     need;
            int     s;
            int     len;
            g = '{granted_offset: '0, status: STATUS_BAD_SIZE};
            if (size == 0 || (int'(size) % GRANULE_BYTES) != 0)
                return g;
            need = int'(size) / GRANULE_BYTES;
            s = 0;
            // Take the lowest free block that fits, splitting off the rest
            while (s < MAP_GRANULES)
            begin
                len = run_length(s);
                if (free_mark[s] && len >= need)
                begin
                    if (len > need)
                    begin
                        start_mark[s + need] = 1'b1;
                        free_mark[s + need]  = 1'b1;
                    end
                    free_mark[s] = 1'b0;
                    g.granted_offset = offset_t'(s * GRANULE_BYTES);
                    g.status = STATUS_OK;
                    return g;
                end
                s += len;
            end
            g.status = STATUS_NO_SPACE;
            return g;
        endfunction

        function grant_t release_block(offset_t off);
            grant_t g;
            int     idx;
            int     nxt;
            int     p;
            g = '{granted_offset: '0, status: STATUS_NO_BLOCK};
            if ((int'(off) % GRANULE_BYTES) != 0)
                return g;
            idx = int'(off) / GRANULE_BYTES;
            if (idx >= MAP_GRANULES || !start_mark[idx])
                return g;
            free_mark[idx] = 1'b1;
            // Absorb a free next block
            nxt = idx + run_length(idx);
            if (nxt < MAP_GRANULES && free_mark[nxt])
            begin
                start_mark[nxt] = 1'b0;
                free_mark[nxt]  = 1'b0;
            end
            // Fold into a free previous block
            p = idx;
            while (p > 0)
            begin
                p--;
                if (start_mark[p])
                begin
                    if (free_mark[p])
                    begin
                        start_mark[idx] = 1'b0;
                        free_mark[idx]  = 1'b0;
                    end
                    break;
                end
            end
            g.status = STATUS_OK;
            return g;
        endfunction

        function void note_request(logic m, bytes_t b, offset_t o);
            if (m == MODE_ALLOC)
                expected_grants.push_back(allocate(b));
            else
                expected_grants.push_back(release_block(o));
        endfunction

        function void check_grant(offset_t off, status_t st);
            grant_t want;
            if (expected_grants.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result offset %0d status %0d", $time, off, st);
                return;
            end
            want = expected_grants.pop_front();
            if (off !== want.granted_offset)
            begin
                errors++;
                $display("%0t: granted_offset expected %0d actual %0d",
                         $time, want.granted_offset, off);
            end
            if (st !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
        endfunction

        function int outstanding();
            return expected_grants.size();
        endfunction

        // Byte offset of a random used (or free) block start, -1 if none
        function int pick_start(bit want_free);
            int picks[$];
            foreach (start_mark[i])
                if (start_mark[i] && free_mark[i] == want_free)
                    picks.push_back(i);
            if (picks.size() == 0)
                return -1;
            return picks[$urandom_range(0, picks.size() - 1)] * GRANULE_BYTES;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   send_steady = 1'b0;
    bit   take_steady = 1'b0;

    block_map_board board;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(logic m, bytes_t b, offset_t o);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= m;
        req_ch.request_bytes <= b;
        req_ch.block_offset  <= o;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(m, b, o);
    endtask

    // Hold off new requests until every outstanding result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // Result side: stall at random, then take and check one result
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_steady = !take_steady;
            stall = take_steady ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            board.check_grant(rsp_ch.granted_offset, rsp_ch.status);
        end
    end

    initial
    begin
        int      kind;
        int      blk;
        int      g;
        logic    m;
        bytes_t  b;
        offset_t o;

        board = new();
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.block_offset  = '0;
        rsp_ch.ready         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Size checks: zero, not a granule multiple, largest field value, beyond the page
        send_request(MODE_ALLOC, 16'd0, 12'hFFF);
        send_request(MODE_ALLOC, 16'd4, 12'h000);
        send_request(MODE_ALLOC, 16'hFFFF, 12'hABC);
        send_request(MODE_ALLOC, 16'hFFF8, 12'h000);
        send_request(MODE_ALLOC, 16'd4104, 12'h000);
        // Free the untouched page, then take it whole
        send_request(MODE_FREE, 16'hFFFF, 12'd0);
        send_request(MODE_ALLOC, 16'd4096, 12'hFFF);
        send_request(MODE_ALLOC, 16'd8, 12'h000);
        send_request(MODE_FREE, 16'h0000, 12'hFFF);
        send_request(MODE_FREE, 16'h0000, 12'd0);
        // Carve several blocks with an exact fit at the end
        send_request(MODE_ALLOC, 16'd8, 12'h000);
        send_request(MODE_ALLOC, 16'd16, 12'h000);
        send_request(MODE_ALLOC, 16'd24, 12'h000);
        send_request(MODE_ALLOC, 16'd4048, 12'h000);
        send_request(MODE_FREE, 16'h0000, 12'd4088);
        // Free between used neighbours, then merge with the previous block
        send_request(MODE_FREE, 16'h0000, 12'd8);
        send_request(MODE_FREE, 16'h0000, 12'd24);
        send_request(MODE_ALLOC, 16'd40, 12'h000);
        send_request(MODE_FREE, 16'h0000, 12'd0);
        send_request(MODE_FREE, 16'h0000, 12'd8);
        send_request(MODE_FREE, 16'h0000, 12'd48);
        send_request(MODE_FREE, 16'h0000, 12'd0);
        // Merge with the next free block
        send_request(MODE_ALLOC, 16'd8, 12'h000);
        send_request(MODE_ALLOC, 16'd8, 12'h000);
        send_request(MODE_FREE, 16'h0000, 12'd8);
        send_request(MODE_FREE, 16'h0000, 12'd0);
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 320 == 319)
                drain_results();
            kind = $urandom_range(0, 99);
            m = MODE_ALLOC;
            b = bytes_t'($urandom);
            o = offset_t'($urandom);
            if (kind < 45)
            begin
                // Mostly small sizes, a few up to the whole page
                g = $urandom_range(0, 99);
                if (g < 70)
                    g = $urandom_range(1, 8);
                else if (g < 92)
                    g = $urandom_range(9, 64);
                else
                    g = $urandom_range(65, MAP_GRANULES);
                b = bytes_t'(g * GRANULE_BYTES);
            end
            else if (kind < 90)
            begin
                blk = board.pick_start(kind >= 85);
                if (blk < 0)
                    b = bytes_t'($urandom_range(1, 8) * GRANULE_BYTES);
                else
                begin
                    m = MODE_FREE;
                    o = offset_t'(blk);
                end
            end
            else
                m = logic'($urandom_range(0, 1));
            send_request(m, b, o);
        end

        // Wait for the last results, then watch for stray ones
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
